[hdl/sorted_key_table_insert_macros.svh]
// Assertion helpers for the sorted key table RTL
`ifndef SORTED_KEY_TABLE_INSERT_MACROS_SVH
`define SORTED_KEY_TABLE_INSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SKTI_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication, disabled in reset
`define SKTI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

[hdl/skti_pkg.sv]
package skti_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_BYTES = 20;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int KH_W      = 32;
    localparam int KM_W      = 64;
    localparam int KL_W      = 64;
    localparam int PHONE_W   = 34;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_DUP   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [KH_W-1:0]    key_high;
        logic [KM_W-1:0]    key_mid;
        logic [KL_W-1:0]    key_low;
        logic [PHONE_W-1:0] phone;
    } entry_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic capture;   // word accepted: latch compare flags
        logic occupied;  // cell index below entry count
        logic sel;       // cell index equals read index
        logic apply;     // insert commits this cycle
        logic last;      // cell index equals entry count
    } cell_ctl_t;

    function automatic logic [IDX_W-1:0] onehot_to_idx(input logic [CAPACITY-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (vec[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[hdl/skti_cell.sv]
module skti_cell
    import skti_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  key_t      cap_key,
    input  entry_t    new_entry,
    input  entry_t    left_entry,
    input  logic      left_gt,
    output entry_t    entry,
    output logic      gt_flag,
    output logic      eq_flag,
    output logic      sel_flag
);

    entry_t entry_reg;
    logic   gt_reg;
    logic   eq_reg;
    logic   sel_reg;
    key_t   stored_key;

    assign stored_key = {entry_reg.key_high, entry_reg.key_mid, entry_reg.key_low};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            sel_reg <= 1'b0;
        end else if (ctl.capture) begin
            // gt: stored entry sorts above the new key and must move up
            gt_reg  <= ctl.occupied && (cap_key < stored_key);
            eq_reg  <= ctl.occupied && (cap_key == stored_key);
            sel_reg <= ctl.sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.apply) begin
            if (left_gt) begin
                entry_reg <= left_entry;
            end else if (gt_reg || ctl.last) begin
                entry_reg <= new_entry;
            end
        end
    end

    assign entry    = entry_reg;
    assign gt_flag  = gt_reg;
    assign eq_flag  = eq_reg;
    assign sel_flag = sel_reg;

endmodule

[hdl/sorted_key_table_insert.sv]
// Sorted key table: a row of cells, one record each, kept in ascending key order.
// Flow: all cells compare in the accept cycle and latch their flags; in ST_APPLY an
// insert shifts the row in place and the result is registered, and a waiting result
// holds ST_APPLY. No new word is taken until the result is registered (s_ready in ST_IDLE).
// Reset: synchronous, active low; clears entry count, handshake state and cell compare flags.
// Cell contents are not cleared; no clearing pass, ready right after reset.
module sorted_key_table_insert
    import skti_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [KH_W-1:0]    s_key_high,
    input  logic [KM_W-1:0]    s_key_mid,
    input  logic [KL_W-1:0]    s_key_low,
    input  logic [PHONE_W-1:0] s_phone,
    input  logic [IDX_W-1:0]   s_read_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [IDX_W-1:0]   m_position,
    output logic [CNT_W-1:0]   m_count,
    output logic [KH_W-1:0]    m_out_key_high,
    output logic [KM_W-1:0]    m_out_key_mid,
    output logic [KL_W-1:0]    m_out_key_low,
    output logic [PHONE_W-1:0] m_out_phone
);

    `include "sorted_key_table_insert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_APPLY = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         req_reg;
    logic [IDX_W-1:0]   ridx_reg;
    entry_t             req_entry_reg;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   cnt_out_reg, cnt_out_next;
    entry_t             rd_reg, rd_next;

    logic               accept;
    logic               out_load;
    logic               dup;
    logic               full;
    logic               ins_ok;
    logic               rd_ok;
    logic [CAPACITY-1:0] gt_vec, eq_vec, sel_vec, tn_vec;
    entry_t             cell_entry [CAPACITY];
    entry_t             rd_sel;
    cell_ctl_t          ctl [CAPACITY];

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_APPLY) && (!m_valid_reg || m_ready);

    assign dup    = |eq_vec;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign ins_ok = (req_reg == REQ_INSERT) && !dup && !full;
    assign rd_ok  = ({1'b0, ridx_reg} < count_reg);

    // cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign ctl[i].capture  = accept;
        assign ctl[i].occupied = (CNT_W'(i) < count_reg);
        assign ctl[i].sel      = (s_read_index == IDX_W'(i));
        assign ctl[i].apply    = out_load && ins_ok;
        assign ctl[i].last     = (count_reg == CNT_W'(i));

        if (i == 0) begin : g_head
            assign tn_vec[i] = gt_vec[i] || ctl[i].last;
            skti_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl[i]),
                .cap_key    ({s_key_high, s_key_mid, s_key_low}),
                .new_entry  (req_entry_reg),
                .left_entry (req_entry_reg),
                .left_gt    (1'b0),
                .entry      (cell_entry[i]),
                .gt_flag    (gt_vec[i]),
                .eq_flag    (eq_vec[i]),
                .sel_flag   (sel_vec[i])
            );
        end else begin : g_body
            assign tn_vec[i] = !gt_vec[i-1] && (gt_vec[i] || ctl[i].last);
            skti_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl[i]),
                .cap_key    ({s_key_high, s_key_mid, s_key_low}),
                .new_entry  (req_entry_reg),
                .left_entry (cell_entry[i-1]),
                .left_gt    (gt_vec[i-1]),
                .entry      (cell_entry[i]),
                .gt_flag    (gt_vec[i]),
                .eq_flag    (eq_vec[i]),
                .sel_flag   (sel_vec[i])
            );
        end
    end

    // read select: and-or over the row
    always_comb begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (sel_vec[i]) begin
                rd_sel = rd_sel | cell_entry[i];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        cnt_out_next = cnt_out_reg;
        rd_next      = rd_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_load) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    status_next  = STAT_DONE;
                    pos_next     = '0;
                    rd_next      = '0;
                    unique case (req_reg)
                        REQ_INSERT: begin
                            if (dup) begin
                                status_next = STAT_DUP;
                                pos_next    = onehot_to_idx(eq_vec);
                            end else if (full) begin
                                status_next = STAT_FULL;
                            end else begin
                                pos_next   = onehot_to_idx(tn_vec);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_READ: begin
                            pos_next = ridx_reg;
                            if (rd_ok) begin
                                rd_next = rd_sel;
                            end else begin
                                status_next = STAT_RANGE;
                            end
                        end
                        REQ_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                    cnt_out_next = count_next;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        cnt_out_reg <= cnt_out_next;
        rd_reg      <= rd_next;
        if (accept) begin
            req_reg                <= s_req_type;
            ridx_reg               <= s_read_index;
            req_entry_reg.key_high <= s_key_high;
            req_entry_reg.key_mid  <= s_key_mid;
            req_entry_reg.key_low  <= s_key_low;
            req_entry_reg.phone    <= s_phone;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_position     = pos_reg;
    assign m_count        = cnt_out_reg;
    assign m_out_key_high = rd_reg.key_high;
    assign m_out_key_mid  = rd_reg.key_mid;
    assign m_out_key_low  = rd_reg.key_low;
    assign m_out_phone    = rd_reg.phone;

    `SKTI_ASSERT_IMPL(a_count_cap, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SKTI_ASSERT_IMPL(a_dup_unique, aclk, aresetn, state_reg == ST_APPLY, $onehot0(eq_vec))
    `SKTI_ASSERT_IMPL(a_slot_onehot, aclk, aresetn, out_load && ins_ok, $onehot(tn_vec))
    `SKTI_ASSERT_NEXT(a_insert_grows, aclk, aresetn, out_load && ins_ok,
        count_reg == $past(count_reg) + CNT_W'(1))

endmodule

[tb/sv/key_table_checker.sv]
module key_table_checker
    import skti_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [KH_W-1:0]    s_key_high,
    input  logic [KM_W-1:0]    s_key_mid,
    input  logic [KL_W-1:0]    s_key_low,
    input  logic [PHONE_W-1:0] s_phone,
    input  logic [IDX_W-1:0]   s_read_index,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_status,
    input  logic [IDX_W-1:0]   m_position,
    input  logic [CNT_W-1:0]   m_count,
    input  logic [KH_W-1:0]    m_out_key_high,
    input  logic [KM_W-1:0]    m_out_key_mid,
    input  logic [KL_W-1:0]    m_out_key_low,
    input  logic [PHONE_W-1:0] m_out_phone,
    output int                 mismatches,
    output int                 in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   position;
        logic [CNT_W-1:0]   count;
        logic [KH_W-1:0]    key_high;
        logic [KM_W-1:0]    key_mid;
        logic [KL_W-1:0]    key_low;
        logic [PHONE_W-1:0] phone;
    } table_reply_t;

    // shadow of the table, kept in ascending key order
    key_t               row_key   [CAPACITY];
    logic [PHONE_W-1:0] row_phone [CAPACITY];
    int unsigned        rows_used;

    table_reply_t       replies_due[$];
    int                 bad = 0;

    initial begin
        mismatches = 0;
        in_flight  = 0;
        rows_used  = 0;
    end

    function automatic table_reply_t apply_to_table(input logic [1:0] req, input key_t key,
                                                    input logic [PHONE_W-1:0] phone,
                                                    input logic [IDX_W-1:0] idx);
        table_reply_t r;
        int           slot;
        bit           found;
        bit           dup;
        r     = '0;
        slot  = rows_used;
        found = 1'b0;
        dup   = 1'b0;
        case (req)
            REQ_INSERT: begin
                for (int i = 0; i < rows_used; i++) begin
                    if (!found) begin
                        if (key == row_key[i]) begin
                            dup   = 1'b1;
                            found = 1'b1;
                            slot  = i;
                        end else if (key < row_key[i]) begin
                            found = 1'b1;
                            slot  = i;
                        end
                    end
                end
                // duplicate wins over full
                if (dup) begin
                    r.status   = STAT_DUP;
                    r.position = IDX_W'(slot);
                end else if (rows_used >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    for (int i = rows_used; i > slot; i--) begin
                        row_key[i]   = row_key[i-1];
                        row_phone[i] = row_phone[i-1];
                    end
                    row_key[slot]   = key;
                    row_phone[slot] = phone;
                    rows_used++;
                    r.status   = STAT_DONE;
                    r.position = IDX_W'(slot);
                end
            end
            REQ_READ: begin
                r.position = idx;
                if (idx >= rows_used) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.status = STAT_DONE;
                    {r.key_high, r.key_mid, r.key_low} = row_key[idx];
                    r.phone = row_phone[idx];
                end
            end
            REQ_CLEAR: begin
                rows_used = 0;
                r.status  = STAT_DONE;
            end
            default: begin
                r.status = STAT_DONE;
            end
        endcase
        r.count = CNT_W'(rows_used);
        return r;
    endfunction

    task automatic report(input string what, input table_reply_t want, input table_reply_t got);
        if (bad < 10) begin
            $display("%s at %0t", what, $realtime);
            $display("  expected: status %0d pos %0d count %0d key %h %h %h phone %h",
                     want.status, want.position, want.count,
                     want.key_high, want.key_mid, want.key_low, want.phone);
            $display("  actual:   status %0d pos %0d count %0d key %h %h %h phone %h",
                     got.status, got.position, got.count,
                     got.key_high, got.key_mid, got.key_low, got.phone);
        end
        bad++;
    endtask

    always @(posedge aclk) begin : watch
        table_reply_t want;
        table_reply_t got;
        if (!aresetn) begin
            replies_due.delete();
            rows_used = 0;
        end else begin
            if (s_valid && s_ready) begin
                replies_due.push_back(apply_to_table(s_req_type,
                                                     {s_key_high, s_key_mid, s_key_low},
                                                     s_phone, s_read_index));
            end
            if (m_valid && m_ready) begin
                got = {m_status, m_position, m_count, m_out_key_high, m_out_key_mid,
                       m_out_key_low, m_out_phone};
                if (replies_due.size() == 0) begin
                    report("result word with nothing expected", '0, got);
                end else begin
                    want = replies_due.pop_front();
                    if (got !== want) begin
                        report("result word mismatch", want, got);
                    end
                end
            end
        end
        mismatches <= bad;
        in_flight  <= replies_due.size();
    end

endmodule

[tb/sv/tb_sorted_key_table_insert.sv]
module tb_sorted_key_table_insert;
    timeunit 1ns;
    timeprecision 1ps;
    import skti_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         NUM_WORDS  = 600;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_req_type;
    logic [KH_W-1:0]    s_key_high;
    logic [KM_W-1:0]    s_key_mid;
    logic [KL_W-1:0]    s_key_low;
    logic [PHONE_W-1:0] s_phone;
    logic [IDX_W-1:0]   s_read_index;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic [IDX_W-1:0]   m_position;
    logic [CNT_W-1:0]   m_count;
    logic [KH_W-1:0]    m_out_key_high;
    logic [KM_W-1:0]    m_out_key_mid;
    logic [KL_W-1:0]    m_out_key_low;
    logic [PHONE_W-1:0] m_out_phone;
    int                 mismatches;
    int                 in_flight;

    logic               calm = 1'b0;
    int                 sent = 0;
    key_t               live_keys[$];   // keys currently held, for dup and index picks

    sorted_key_table_insert i_dut (.*);

    key_table_checker i_checker (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 19);
    end

    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 64'd1;
            2:       return '1;
            3:       return 64'h8000_0000_8000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // shared prefixes are common so that compares reach the lower words
    function automatic key_t fresh_key();
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        a = pick64();
        b = pick64();
        c = pick64();
        return {a[31:0], b, c};
    endfunction

    function automatic bit is_live(input key_t key);
        foreach (live_keys[i]) begin
            if (live_keys[i] == key) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [PHONE_W-1:0] rand_phone();
        return PHONE_W'({$urandom, $urandom});
    endfunction

    task automatic send(input logic [1:0] req, input key_t key,
                        input logic [PHONE_W-1:0] ph, input logic [IDX_W-1:0] idx);
        if (!calm) begin
            while ($urandom_range(0, 99) < 19) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        {s_key_high, s_key_mid, s_key_low} <= key;
        s_phone      <= ph;
        s_read_index <= idx;
        do @(posedge aclk); while (!s_ready);
        sent++;
        calm <= (sent >= 250 && sent < 400);
        if (req == REQ_INSERT && !is_live(key) && live_keys.size() < CAPACITY) begin
            live_keys.push_back(key);
        end else if (req == REQ_CLEAR) begin
            live_keys.delete();
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (in_flight != 0);
    endtask

    task automatic read_any();
        logic [IDX_W-1:0] idx;
        if (live_keys.size() > 0 && $urandom_range(0, 4) != 0) begin
            idx = IDX_W'($urandom_range(0, live_keys.size() - 1));
        end else begin
            idx = IDX_W'($urandom_range(0, 63));
        end
        send(REQ_READ, fresh_key(), rand_phone(), idx);
    endtask

    task automatic insert_any(input bool_dup);
        key_t key;
        if (bool_dup && live_keys.size() > 0) begin
            key = live_keys[$urandom_range(0, live_keys.size() - 1)];
        end else begin
            key = fresh_key();
        end
        send(REQ_INSERT, key, rand_phone(), IDX_W'($urandom_range(0, 63)));
    endtask

    task automatic random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            insert_any(1'b0);
        end else if (r < 50) begin
            insert_any(1'b1);
        end else if (r < 88) begin
            read_any();
        end else if (r < 91) begin
            send(REQ_CLEAR, fresh_key(), rand_phone(), IDX_W'($urandom_range(0, 63)));
        end else if (r < 94) begin
            send(REQ_UNUSED, fresh_key(), rand_phone(), IDX_W'($urandom_range(0, 63)));
        end else begin
            insert_any(1'b0);
        end
    endtask

    // empty the table, fill it to capacity, then poke at the full table
    task automatic fill_run();
        drain();
        send(REQ_CLEAR, fresh_key(), rand_phone(), '0);
        while (live_keys.size() < CAPACITY) begin
            insert_any(1'b0);
        end
        repeat (3) insert_any(1'b0);
        repeat (3) insert_any(1'b1);
        repeat (8) read_any();
        send(REQ_READ, '0, '0, '1);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = REQ_INSERT;
        s_key_high   = '0;
        s_key_mid    = '0;
        s_key_low    = '0;
        s_phone      = '0;
        s_read_index = '0;
        m_ready      = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reads on an empty table
        send(REQ_READ, '0, '0, '0);
        send(REQ_READ, '1, '1, '1);
        // insert into empty table, then keys differing in one word each
        send(REQ_INSERT, '0, '0, '0);
        send(REQ_INSERT, '1, '1, '1);
        send(REQ_INSERT, key_t'(1) << 128, rand_phone(), '0);
        send(REQ_INSERT, key_t'(1) << 64, rand_phone(), '0);
        send(REQ_INSERT, key_t'(1), rand_phone(), '1);
        // duplicates at both ends
        send(REQ_INSERT, '0, '1, '0);
        send(REQ_INSERT, '1, '0, '0);
        for (int i = 0; i < 6; i++) begin
            send(REQ_READ, fresh_key(), rand_phone(), IDX_W'(i));
        end
        send(REQ_UNUSED, '1, '1, '1);
        send(REQ_CLEAR, '1, '1, '1);
        // stale data must stay hidden after a clear
        send(REQ_READ, '0, '0, '0);
        send(REQ_INSERT, key_t'(1) << 159, rand_phone(), '0);
        send(REQ_READ, '0, '0, '0);
        send(REQ_CLEAR, '0, '0, '0);
        drain();

        fill_run();
        while (sent < NUM_WORDS) begin
            if ($urandom_range(0, 9) == 0) begin
                fill_run();
            end else begin
                repeat (20) random_op();
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && in_flight == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
